>>> design/pmul_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial multiplier package
// Sizes, command codes, state codes and the structs shared by the block.
// ----------------------------------------------------------------------------
package pmul_pkg;

   localparam int MAX_TERMS   = 32;
   localparam int COEF_WIDTH  = 16;
   localparam int REQ_COEF_W  = 16;
   localparam int PROD_W      = 37;
   localparam int POWER_W     = 6;
   localparam int ADDR_W      = $clog2(MAX_TERMS);
   localparam int CNT_W       = $clog2(MAX_TERMS + 1);
   localparam int POW_W       = $clog2(2 * MAX_TERMS - 1);
   localparam int REQ_DATA_W  = ((REQ_COEF_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((PROD_W + POWER_W + 7) / 8) * 8;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_MUL    = 2'd2
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_ISSUE = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic valid;
      logic first;
   } mac_ctl_type;

   typedef struct packed {
      logic               load;
      logic [POWER_W-1:0] power;
      logic               last;
      logic               err;
   } emit_type;

   function automatic coef_type coef_trim(input logic [REQ_COEF_W-1:0] raw);
      logic [31:0] wide;
      wide = 32'(raw);
      return wide[COEF_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

>>> design/pmul_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pmul_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> design/pmul_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial multiplier multiply-accumulate unit
// One shared multiplier, registered, feeding a wide accumulator.
// ----------------------------------------------------------------------------
module pmul_mac
   import pmul_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mac_ctl_type       mac_ctl,
   input  wire coef_type          opnd_a,
   input  wire coef_type          opnd_b,
   output logic [PROD_W-1:0]      acc
);

   mac_ctl_type tag1_ff, tag1_in, tag2_ff, tag2_in;
   logic signed [2*COEF_WIDTH-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0]       prod_ext;
   logic [PROD_W-1:0]              acc_ff, acc_in;

   always_comb begin
      tag1_in  = mac_ctl;
      tag2_in  = tag1_ff;
      prod_in  = opnd_a * opnd_b;
      prod_ext = PROD_W'(prod_ff);
      acc_in   = acc_ff;
      if (tag2_ff.valid) begin
         acc_in = tag2_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag2_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

>>> design/pmul_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial multiplier sequencer
// Takes load and multiply items, keeps the operand counts and walks the
// convolution terms through the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module pmul_ctrl
   import pmul_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            req_cmd,
   input  wire logic                  out_free,
   output logic                       wr_a,
   output logic                       wr_b,
   output logic [ADDR_W-1:0]          wr_addr_a,
   output logic [ADDR_W-1:0]          wr_addr_b,
   output logic [ADDR_W-1:0]          rd_addr_a,
   output logic [ADDR_W-1:0]          rd_addr_b,
   output mac_ctl_type                mac_ctl,
   output emit_type                   emit
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [POW_W-1:0]   p_ff, p_in;
   logic [ADDR_W-1:0]  i_ff, i_in;
   logic               drain_ff, drain_in;
   logic               err_ff, err_in;

   logic [POW_W:0]     p_ext, ca_ext, cb_ext, top_w, lo_w, hi_w, j_w;
   logic [ADDR_W-1:0]  i_lo, i_hi;
   logic               p_last, accept;

   always_comb begin
      p_ext  = (POW_W+1)'(p_ff);
      ca_ext = (POW_W+1)'(cnt_a_ff);
      cb_ext = (POW_W+1)'(cnt_b_ff);
      top_w  = ca_ext + cb_ext - (POW_W+1)'(2);
      p_last = (p_ext == top_w);
      lo_w   = p_ext - cb_ext + (POW_W+1)'(1);
      i_lo   = (p_ext >= cb_ext) ? lo_w[ADDR_W-1:0] : '0;
      hi_w   = ca_ext - (POW_W+1)'(1);
      i_hi   = (p_ext < ca_ext) ? p_ext[ADDR_W-1:0] : hi_w[ADDR_W-1:0];
      j_w    = p_ext - (POW_W+1)'(i_ff);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign wr_addr_a  = cnt_a_ff[ADDR_W-1:0];
   assign wr_addr_b  = cnt_b_ff[ADDR_W-1:0];
   assign rd_addr_a  = i_ff;
   assign rd_addr_b  = j_w[ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      p_in          = p_ff;
      i_in          = i_ff;
      drain_in      = drain_ff;
      err_in        = err_ff;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      mac_ctl       = '0;
      emit.load     = 1'b0;
      emit.power    = err_ff ? '0 : POWER_W'(p_ff);
      emit.last     = err_ff || p_last;
      emit.err      = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_LOAD_A: begin
                     if (cnt_a_ff < CNT_W'(MAX_TERMS)) begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + CNT_W'(1);
                     end
                  end
                  CMD_LOAD_B: begin
                     if (cnt_b_ff < CNT_W'(MAX_TERMS)) begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + CNT_W'(1);
                     end
                  end
                  CMD_MUL: begin
                     p_in = '0;
                     if (cnt_a_ff == '0 || cnt_b_ff == '0) begin
                        err_in   = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        err_in   = 1'b0;
                        state_in = ST_SETUP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SETUP: begin
            i_in     = i_lo;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            mac_ctl.valid = 1'b1;
            mac_ctl.first = (i_ff == i_lo);
            if (i_ff == i_hi) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               i_in = i_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit.load = 1'b1;
               if (emit.last) begin
                  cnt_a_in = '0;
                  cnt_b_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  p_in     = p_ff + POW_W'(1);
                  state_in = ST_SETUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
      end
      p_ff     <= p_in;
      i_ff     <= i_in;
      drain_ff <= drain_in;
      err_ff   <= err_in;
   end

   a_mul_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_MUL |=> state_ff != ST_IDLE)
      else $error("multiply item did not start the sequencer");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_a_ff <= CNT_W'(MAX_TERMS) && cnt_b_ff <= CNT_W'(MAX_TERMS))
      else $error("operand count beyond store size");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |-> i_ff >= i_lo && i_ff <= i_hi)
      else $error("term index outside the convolution window");

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      emit.load && emit.err |-> emit.last)
      else $error("error item not marked last");

endmodule
`default_nettype wire

>>> design/polynomial_multiplier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial multiplier
// Loads two coefficient lists and emits the coefficients of their product.
//
//   channel | ports      | tdata                           | tuser / tlast
//   --------+------------+---------------------------------+------------------
//   request | req_*      | coefficient                     | tuser: cmd
//   result  | rsp_*      | product_coefficient, power      | tuser: empty_error
//                                                           | tlast: last
//
// A load item is written to its store on acceptance and the sequencer stays
// ready. A multiply item is accepted, then per output power the sequencer
// runs setup, issues one term per cycle, drains the pipeline and hands the
// coefficient off. An empty operand is accepted and hands off one error item.
// A stalled result channel holds the sequencer only at that hand-off.
// Reset clears the counts and the sequencer; the stores need no clearing.
// ----------------------------------------------------------------------------
module polynomial_multiplier
   import pmul_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // coefficient
   input  wire logic [1:0]            req_tuser,   // cmd
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // product_coefficient, power
   output logic                       rsp_tlast,
   output logic                       rsp_tuser    // empty_error
);

   logic                       wr_a, wr_b, out_free;
   logic [ADDR_W-1:0]          wr_addr_a, wr_addr_b, rd_addr_a, rd_addr_b;
   coef_type                   coef_in, opnd_a, opnd_b;
   mac_ctl_type                mac_ctl;
   emit_type                   emit;
   logic [PROD_W-1:0]          acc;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_err_ff, rsp_err_in;

   assign coef_in = coef_trim(req_tdata[REQ_COEF_W-1:0]);

   pmul_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .out_free   (out_free),
      .wr_a       (wr_a),
      .wr_b       (wr_b),
      .wr_addr_a  (wr_addr_a),
      .wr_addr_b  (wr_addr_b),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .mac_ctl    (mac_ctl),
      .emit       (emit)
   );

   pmul_ram #(.WIDTH(COEF_WIDTH), .DEPTH(MAX_TERMS)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr_a),
      .wr_data (coef_in),
      .rd_addr (rd_addr_a),
      .rd_data (opnd_a)
   );

   pmul_ram #(.WIDTH(COEF_WIDTH), .DEPTH(MAX_TERMS)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr_b),
      .wr_data (coef_in),
      .rd_addr (rd_addr_b),
      .rd_data (opnd_b)
   );

   pmul_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_ctl (mac_ctl),
      .opnd_a  (opnd_a),
      .opnd_b  (opnd_b),
      .acc     (acc)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({emit.power, (emit.err ? '0 : acc)});
         rsp_last_in  = emit.last;
         rsp_err_in   = emit.err;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
`default_nettype wire
